@@ design/sitda_pkg.sv @@
package sitda_pkg;

  // Reciprocal of ten for 32-bit operands: q = (n * RECIP_10) >> QUOT_SHIFT
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          QUOT_SHIFT = 35;
  localparam int          QUOT_W     = 64 - QUOT_SHIFT;

  localparam int          MAX_DIGITS = 10;
  localparam int          DIGIT_IDX_W = 4;
  localparam int          COUNT_W    = 4;

  localparam logic [7:0]  CHAR_MINUS = 8'd45;
  localparam logic [7:0]  CHAR_ZERO  = 8'd48;
  localparam logic [7:0]  CHAR_NINE  = 8'd57;

  localparam logic [COUNT_W-1:0] MAX_CHARS = 4'd11;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_EMIT
  } state_t;

endpackage

@@ design/sitda_div10.sv @@
module sitda_div10 (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] dividend,
  output logic [31:0] quot,
  output sitda_pkg::digit_t rem
);
  import sitda_pkg::*;

  logic [63:0]       prod_r;
  logic [31:0]       dvd_r;
  logic [QUOT_W-1:0] q;
  logic [3:0]        q_x10_lo;

  // Register the reciprocal product and the operand it belongs to
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {32'd0, dividend} * {32'd0, RECIP_10};
      dvd_r  <= dividend;
    end
  end

  // Quotient from the upper product bits; remainder is below ten, so four bits suffice
  always_comb begin
    q        = prod_r[63:QUOT_SHIFT];
    q_x10_lo = {q[0], 3'd0} + {q[2:0], 1'b0};
    quot     = {{(32-QUOT_W){1'b0}}, q};
    rem      = dvd_r[3:0] - q_x10_lo;
  end

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text.
// Input channel in_*: one transfer carries a two's complement value in in_tdata.
// Output channel out_*: one transfer per character, most significant first:
//   an optional '-' then the digits of the magnitude, no leading zeros, a
//   single '0' for zero. out_tlast marks the final character, and out_tuser
//   then carries the character count (1 to 11), else zero.
// Digits are produced least significant first by one shared divide-by-ten
// unit (a registered 32x32 reciprocal multiply plus a short fix-up), each
// digit taking an ST_MUL and an ST_SPLIT step, and are stored in a small
// digit buffer. The first character is presented once all D digits (1 to
// 10) are stored. Characters then leave at one per cycle while out_tready
// is high. An item has C characters (D, or D+1 with a sign); in_tready is
// high only while the block is idle.
// A stalled receiver holds the output register and freezes character
// emission; a new value can be taken while the last character still waits.
// Reset (rst_n low, synchronous) empties the output register and returns to idle.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] char_code
  output logic        out_tlast,  // is_last
  output logic [3:0]  out_tuser   // [3:0] char_count
);
  import sitda_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0]            mag_r, mag_nxt;
  logic                   sign_pend_r, sign_pend_nxt;
  logic [DIGIT_IDX_W-1:0] nd_r, nd_nxt;
  logic [DIGIT_IDX_W-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0]     emitted_r, emitted_nxt;
  digit_t                 digits_r [MAX_DIGITS];

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;
  logic [3:0]  out_count_r, out_count_nxt;

  logic        in_xfer;
  logic        div_en;
  logic [31:0] div_quot;
  digit_t      div_rem;
  logic        digit_wr;
  logic        slot_free;

  sitda_div10 u_div10 (
    .clk      (clk),
    .en       (div_en),
    .dividend (mag_r),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Next state, digit sequencing and character emission
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    sign_pend_nxt = sign_pend_r;
    nd_nxt        = nd_r;
    pos_nxt       = pos_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    div_en        = 1'b0;
    digit_wr      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sign_pend_nxt = in_tdata[31];
          mag_nxt       = in_tdata[31] ? (32'd0 - in_tdata) : in_tdata;
          nd_nxt        = '0;
          emitted_nxt   = '0;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        div_en    = 1'b1;
        state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        digit_wr = 1'b1;
        nd_nxt   = nd_r + 1'b1;
        mag_nxt  = div_quot;
        if (div_quot == 32'd0) begin
          pos_nxt   = nd_r;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          emitted_nxt   = emitted_r + 1'b1;
          if (sign_pend_r) begin
            sign_pend_nxt = 1'b0;
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            out_count_nxt = '0;
          end else begin
            out_char_nxt = CHAR_ZERO + {4'd0, digits_r[pos_r]};
            if (pos_r == '0) begin
              out_last_nxt  = 1'b1;
              out_count_nxt = emitted_r + 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              out_last_nxt  = 1'b0;
              out_count_nxt = '0;
              pos_nxt       = pos_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    sign_pend_r <= sign_pend_nxt;
    nd_r        <= nd_nxt;
    pos_r       <= pos_nxt;
    emitted_r   <= emitted_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  // Digit buffer, filled least significant first
  always_ff @(posedge clk) begin
    if (digit_wr) begin
      digits_r[nd_r] <= div_rem;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_count_r;

  // A count is reported exactly on the final character, within range
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast ? (out_tuser != 4'd0 && out_tuser <= MAX_CHARS)
                              : (out_tuser == 4'd0)))
    else $error("character count inconsistent with last flag");

  // Only a minus sign or a decimal digit is ever presented
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == CHAR_MINUS ||
                    (out_tdata >= CHAR_ZERO && out_tdata <= CHAR_NINE)))
    else $error("character outside the decimal set");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign marked as last");

  // An accepted value keeps the input closed on the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input reopened right after a transfer");

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sitda_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_PRINTS   = 40;

  // One expected character of the decimal text
  typedef struct packed {
    logic [7:0]         code;
    logic               last;
    logic [COUNT_W-1:0] count;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [3:0]  out_tuser;

  logic [31:0] values_to_send[$];
  text_char_t  chars_due[$];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          phase_no = 0;
  bit          rcv_hold = 1'b0;
  int          mismatches = 0;

  signed_int_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Queue up the characters of the decimal text of one value
  task automatic predict_decimal_text(logic [31:0] value);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digits[MAX_DIGITS];
    int          n_digits;
    int          n_chars;
    text_char_t  ch;
    negative  = value[31];
    magnitude = negative ? (32'd0 - value) : value;
    n_digits  = 0;
    do begin
      digits[n_digits] = 4'(magnitude % 32'd10);
      magnitude = magnitude / 32'd10;
      n_digits++;
    end while (magnitude != 0 && n_digits < MAX_DIGITS);
    n_chars = n_digits + (negative ? 1 : 0);
    if (negative) begin
      ch.code  = CHAR_MINUS;
      ch.last  = 1'b0;
      ch.count = '0;
      chars_due.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code  = CHAR_ZERO + 8'(digits[i]);
      ch.last  = (i == 0);
      ch.count = (i == 0) ? COUNT_W'(n_chars) : '0;
      chars_due.push_back(ch);
    end
  endtask

  // Random value, mostly spread evenly over the digit counts
  function automatic logic [31:0] random_value();
    longint lo;
    longint hi;
    int     n_digits;
    logic [31:0] mag;
    if ($urandom_range(9) < 2) return $urandom;
    n_digits = $urandom_range(1, 10);
    lo = (n_digits == 1) ? 0 : 1;
    hi = 1;
    for (int i = 1; i < n_digits; i++) begin
      if (n_digits > 1) lo = lo * 10;
      hi = hi * 10;
    end
    hi = hi * 10 - 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    mag = $urandom_range(32'(hi), 32'(lo));
    if ($urandom_range(1)) return 32'd0 - mag;
    return mag;
  endfunction

  // Driver: offer the next value once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_decimal_text(in_tdata);
      if (values_to_send.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tdata  <= values_to_send.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each character transfer against the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (chars_due.size() == 0) begin
          report_mismatch("unexpected character", out_tdata, -1);
        end else begin
          want = chars_due.pop_front();
          if (out_tdata !== want.code) report_mismatch("char_code", out_tdata, want.code);
          if (out_tlast !== want.last) report_mismatch("is_last", out_tlast, want.last);
          if (out_tuser !== want.count) report_mismatch("char_count", out_tuser, want.count);
        end
      end
      out_tready <= !rcv_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering values
  initial begin
    wait (phase_no == 3);
    @(negedge clk);
    rcv_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    rcv_hold = 1'b0;
  end

  // Wait until every value is taken and every character has arrived
  task automatic wait_drained();
    while (values_to_send.size() != 0 || in_tvalid || chars_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int phase, int send_idle, int recv_stall, int n_random);
    @(negedge clk);
    phase_no  = phase;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n_random) values_to_send.push_back(random_value());
    wait_drained();
  endtask

  // Stimulus: directed corner values, then random phases
  initial begin
    logic [31:0] corner_values[];
    corner_values = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'd2147483647, 32'h8000_0000, -32'sd2147483647, 32'd1000000000,
      32'd999999999, -32'sd1000000000, -32'sd999999999, 32'd1234567890,
      -32'sd123, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'd7, 32'd0};
    wait (rst_n === 1'b1);
    @(negedge clk);
    foreach (corner_values[i]) values_to_send.push_back(corner_values[i]);
    wait_drained();
    run_phase(1, 0, 0, 55);
    run_phase(2, 81, 0, 55);
    run_phase(3, 0, 81, 63);
    run_phase(4, 28, 28, 63);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chars_due.size() != 0) report_mismatch("characters never sent", 0, chars_due.size());
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/sitda_pkg.sv
design/sitda_div10.sv
design/signed_int_to_decimal_ascii.sv
test/tb_top.sv
